// ----- design/sha1bsh_pkg.sv -----
// sha1bsh_pkg: shared types and constants of the SHA-1 byte stream hasher.
// Used by sha1bsh_ctrl, sha1bsh_dp and the top level; no dependencies.
`timescale 1ns / 1ps
package sha1bsh_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned DigestW    = 5 * WordW;
  localparam int unsigned BlockW     = 512;
  localparam int unsigned LenW       = 61;
  localparam int unsigned CfgW       = 5;
  localparam int unsigned DigestLen  = 20;
  localparam logic [CfgW-1:0] DigestBytesReset = 5'd20;
  localparam logic [6:0] RoundLast   = 7'd79;
  localparam logic [7:0] PadMark     = 8'h80;

  localparam logic [WordW-1:0] Iv0 = 32'h67452301;
  localparam logic [WordW-1:0] Iv1 = 32'hEFCDAB89;
  localparam logic [WordW-1:0] Iv2 = 32'h98BADCFE;
  localparam logic [WordW-1:0] Iv3 = 32'h10325476;
  localparam logic [WordW-1:0] Iv4 = 32'hC3D2E1F0;

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_ADD   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    SEL_IN   = 2'd0,
    SEL_MARK = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic      shift_en;   // shift one byte into the block window
    byte_sel_t byte_sel;
    logic [2:0] len_idx;   // which length byte, 0 = most significant
    logic      len_inc;
    logic      load_work;  // a..e <= chaining words
    logic      round_en;
    logic [1:0] round_grp; // 20-round group
    logic      add_en;     // fold a..e into chaining words
    logic      out_load;   // capture digest, restart message
  } cmd_t;

endpackage

// ----- design/sha1_byte_stream_hasher_unit.sv -----
// sha1_byte_stream_hasher_unit: SHA-1 over a byte stream, digest per message.
// Top level; instantiates sha1bsh_ctrl and sha1bsh_dp, uses sha1bsh_pkg.
//
//   channel  dir  bits        transfer carries
//   s_*      in   8 + 1 + 1   message byte, byte flag (tuser), end of message (tlast)
//   m_*      out  160         digest words 0..4, word 0 lowest
//   cfg_*    in   5           digest_bytes, written whenever cfg_we is high
//
// Bytes are taken one per cycle while s_tready is high. Each 64th byte
// starts a compression on the single round unit (rounds, then an add
// step), no input taken. The closing transfer adds pad bytes, one per
// cycle, to the block's end (up to two blocks), a compression per padded block
// and a hand-off. The digest register lets new bytes in while m_tvalid waits;
// a second digest stalls only until the first one is taken. Reset is synchronous.
`timescale 1ns / 1ps
module sha1_byte_stream_hasher_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,  // [7:0] message_byte
  input  logic                                s_tuser,  // [0] byte_valid
  input  logic                                s_tlast,  // is_last
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [31:0] digest_word0, [63:32] word1, [95:64] word2,
  // [127:96] word3, [159:128] digest_word4
  output logic [sha1bsh_pkg::DigestW-1:0]     m_tdata,
  input  logic                                cfg_we,
  input  logic [sha1bsh_pkg::CfgW-1:0]        cfg_data  // digest_bytes
);

  sha1bsh_pkg::cmd_t cmd;

  sha1bsh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .byte_valid (s_tuser),
    .is_last    (s_tlast),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .cmd        (cmd)
  );

  sha1bsh_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .message_byte (s_tdata),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .digest       (m_tdata)
  );

endmodule

// ----- design/sha1bsh_ctrl.sv -----
// sha1bsh_ctrl: sequencer for byte intake, padding, rounds and digest hand-off.
// Depends on sha1bsh_pkg; drives sha1bsh_dp through a cmd_t bundle.
`timescale 1ns / 1ps
module sha1bsh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              byte_valid,
  input  logic              is_last,
  output logic              out_valid,
  input  logic              out_ready,
  output sha1bsh_pkg::cmd_t cmd
);

  sha1bsh_pkg::state_t state, state_next;
  logic [5:0] fill, fill_next;
  logic [6:0] rcnt, rcnt_next;
  logic       finishing, finishing_next;
  logic       mark, mark_next;
  logic       len_ok, len_ok_next;
  logic       final_blk, final_blk_next;
  logic       out_valid_next;
  logic       accept;

  assign in_ready = (state == sha1bsh_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    rcnt_next      = rcnt;
    finishing_next = finishing;
    mark_next      = mark;
    len_ok_next    = len_ok;
    final_blk_next = final_blk;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.byte_sel   = sha1bsh_pkg::SEL_IN;
    cmd.len_idx    = fill[2:0];
    if (rcnt < 7'd20) begin
      cmd.round_grp = 2'd0;
    end else if (rcnt < 7'd40) begin
      cmd.round_grp = 2'd1;
    end else if (rcnt < 7'd60) begin
      cmd.round_grp = 2'd2;
    end else begin
      cmd.round_grp = 2'd3;
    end

    case (state)
      sha1bsh_pkg::S_IDLE: begin
        if (accept) begin
          finishing_next = is_last;
          mark_next      = is_last;
          if (byte_valid) begin
            cmd.shift_en = 1'b1;
            cmd.len_inc  = 1'b1;
            fill_next    = fill + 6'd1;
          end
          if (byte_valid && fill == 6'd63) begin
            cmd.load_work  = 1'b1;
            final_blk_next = 1'b0;
            state_next     = sha1bsh_pkg::S_ROUND;
          end else if (is_last) begin
            state_next = sha1bsh_pkg::S_PAD;
          end
        end
      end
      sha1bsh_pkg::S_PAD: begin
        cmd.shift_en = 1'b1;
        fill_next    = fill + 6'd1;
        if (mark) begin
          cmd.byte_sel = sha1bsh_pkg::SEL_MARK;
          mark_next    = 1'b0;
          len_ok_next  = (fill <= 6'd55);
        end else if (len_ok && fill >= 6'd56) begin
          cmd.byte_sel = sha1bsh_pkg::SEL_LEN;
        end else begin
          cmd.byte_sel = sha1bsh_pkg::SEL_ZERO;
        end
        if (fill == 6'd63) begin
          cmd.load_work  = 1'b1;
          final_blk_next = !mark && len_ok;
          state_next     = sha1bsh_pkg::S_ROUND;
        end
      end
      sha1bsh_pkg::S_ROUND: begin
        cmd.round_en = 1'b1;
        if (rcnt == sha1bsh_pkg::RoundLast) begin
          rcnt_next  = '0;
          state_next = sha1bsh_pkg::S_ADD;
        end else begin
          rcnt_next = rcnt + 7'd1;
        end
      end
      sha1bsh_pkg::S_ADD: begin
        cmd.add_en = 1'b1;
        if (final_blk) begin
          state_next = sha1bsh_pkg::S_DONE;
        end else if (finishing) begin
          // block filled before the length fit: next block takes it
          len_ok_next = 1'b1;
          state_next  = sha1bsh_pkg::S_PAD;
        end else begin
          state_next = sha1bsh_pkg::S_IDLE;
        end
      end
      sha1bsh_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          finishing_next = 1'b0;
          final_blk_next = 1'b0;
          fill_next      = '0;
          state_next     = sha1bsh_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sha1bsh_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha1bsh_pkg::S_IDLE;
      fill      <= '0;
      rcnt      <= '0;
      finishing <= 1'b0;
      mark      <= 1'b0;
      len_ok    <= 1'b0;
      final_blk <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      rcnt      <= rcnt_next;
      finishing <= finishing_next;
      mark      <= mark_next;
      len_ok    <= len_ok_next;
      final_blk <= final_blk_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- design/sha1bsh_dp.sv -----
// sha1bsh_dp: block window, message schedule, round unit, chaining words,
// byte count and digest output register. Depends on sha1bsh_pkg.
`timescale 1ns / 1ps
module sha1bsh_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sha1bsh_pkg::cmd_t                    cmd,
  input  logic [7:0]                           message_byte,
  input  logic                                 cfg_we,
  input  logic [sha1bsh_pkg::CfgW-1:0]         cfg_data,
  output logic [sha1bsh_pkg::DigestW-1:0]      digest
);

  localparam int unsigned W = sha1bsh_pkg::WordW;

  // 64-byte window; oldest byte / schedule word sits in the top bits
  logic [sha1bsh_pkg::BlockW-1:0] win;
  logic [W-1:0] cv0, cv1, cv2, cv3, cv4;
  logic [W-1:0] a, b, c, d, e;
  logic [sha1bsh_pkg::LenW-1:0] len;
  logic [sha1bsh_pkg::CfgW-1:0] digest_bytes;

  logic [63:0]  len_bits;
  logic [2:0]   len_rev;
  logic [7:0]   pad_len_byte;
  logic [7:0]   shift_byte;
  logic [W-1:0] w0, w2, w8, w13, wx, wnew;
  logic [W-1:0] f, k, temp;
  logic [sha1bsh_pkg::CfgW-1:0] keep;
  logic [sha1bsh_pkg::DigestW-1:0] cv_flat, masked;

  assign len_bits     = {len, 3'b000};
  assign len_rev      = 3'd7 - cmd.len_idx;
  assign pad_len_byte = len_bits[{len_rev, 3'b000} +: 8];

  always_comb begin
    case (cmd.byte_sel)
      sha1bsh_pkg::SEL_IN:   shift_byte = message_byte;
      sha1bsh_pkg::SEL_MARK: shift_byte = sha1bsh_pkg::PadMark;
      sha1bsh_pkg::SEL_LEN:  shift_byte = pad_len_byte;
      default:               shift_byte = '0;
    endcase
  end

  // W[t] at the top; W[t+16] = rotl1(W[t+13] ^ W[t+8] ^ W[t+2] ^ W[t])
  assign w0   = win[511:480];
  assign w2   = win[447:416];
  assign w8   = win[255:224];
  assign w13  = win[95:64];
  assign wx   = w13 ^ w8 ^ w2 ^ w0;
  assign wnew = {wx[W-2:0], wx[W-1]};

  always_comb begin
    case (cmd.round_grp)
      2'd0: begin
        f = (b & c) | (~b & d);
        k = sha1bsh_pkg::K0;
      end
      2'd1: begin
        f = b ^ c ^ d;
        k = sha1bsh_pkg::K1;
      end
      2'd2: begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1bsh_pkg::K2;
      end
      default: begin
        f = b ^ c ^ d;
        k = sha1bsh_pkg::K3;
      end
    endcase
  end

  assign temp = {a[W-6:0], a[W-1:W-5]} + f + e + k + w0;

  assign keep    = (digest_bytes > 5'(sha1bsh_pkg::DigestLen)) ?
                   5'(sha1bsh_pkg::DigestLen) : digest_bytes;
  assign cv_flat = {cv4, cv3, cv2, cv1, cv0};

  always_comb begin
    masked = '0;
    for (int j = 0; j < sha1bsh_pkg::DigestLen; j++) begin
      if (5'(j) < keep) begin
        masked[(j / 4) * W + (3 - (j % 4)) * 8 +: 8] =
          cv_flat[(j / 4) * W + (3 - (j % 4)) * 8 +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      win <= {win[sha1bsh_pkg::BlockW-9:0], shift_byte};
    end else if (cmd.round_en) begin
      win <= {win[sha1bsh_pkg::BlockW-W-1:0], wnew};
    end
    if (cmd.load_work) begin
      a <= cv0;
      b <= cv1;
      c <= cv2;
      d <= cv3;
      e <= cv4;
    end else if (cmd.round_en) begin
      a <= temp;
      b <= a;
      c <= {b[1:0], b[W-1:2]};
      d <= c;
      e <= d;
    end
    if (cmd.out_load) begin
      digest <= masked;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv0          <= sha1bsh_pkg::Iv0;
      cv1          <= sha1bsh_pkg::Iv1;
      cv2          <= sha1bsh_pkg::Iv2;
      cv3          <= sha1bsh_pkg::Iv3;
      cv4          <= sha1bsh_pkg::Iv4;
      len          <= '0;
      digest_bytes <= sha1bsh_pkg::DigestBytesReset;
    end else begin
      if (cfg_we) begin
        digest_bytes <= cfg_data;
      end
      if (cmd.out_load) begin
        cv0 <= sha1bsh_pkg::Iv0;
        cv1 <= sha1bsh_pkg::Iv1;
        cv2 <= sha1bsh_pkg::Iv2;
        cv3 <= sha1bsh_pkg::Iv3;
        cv4 <= sha1bsh_pkg::Iv4;
        len <= '0;
      end else begin
        if (cmd.add_en) begin
          cv0 <= cv0 + a;
          cv1 <= cv1 + b;
          cv2 <= cv2 + c;
          cv3 <= cv3 + d;
          cv4 <= cv4 + e;
        end
        if (cmd.len_inc) begin
          len <= len + 61'd1;
        end
      end
    end
  end

endmodule
